>>> design/isotp_flow_controlled_sender_defines.svh
// assertion macros used by the checker file of the segmenting sender
`ifndef ISOTP_FLOW_CONTROLLED_SENDER_DEFINES_SVH
`define ISOTP_FLOW_CONTROLLED_SENDER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/isotp_fcs_pkg.sv
// shared constants, codes and types of the segmenting sender
package isotp_fcs_pkg;

  // payload store geometry
  localparam int unsigned BUFFER_BYTES = 128;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int unsigned CNT_W        = $clog2(BUFFER_BYTES + 1);

  // job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // frame layout
  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned SLOT_W      = $clog2(FRAME_BYTES);
  localparam int unsigned CF_DATA     = FRAME_BYTES - 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // reset values of the registers
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [7:0]  ACK_RESET     = 8'h74;

  // protocol control bytes
  localparam logic [7:0] CF_PCI       = 8'h20;
  localparam logic [3:0] FC_PCI_HI    = 4'h3;
  localparam logic [3:0] FC_CONTINUE  = 4'h0;
  localparam logic [3:0] FC_WAIT      = 4'h1;
  localparam logic [3:0] FC_MIN_LEN   = 4'd3;
  localparam logic [3:0] ACK_MIN_LEN  = 4'd1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_REPLY  = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    EV_FRAME    = 3'd0,
    EV_COMPLETE = 3'd1,
    EV_ABORT    = 3'd2,
    EV_TIMEOUT  = 3'd3,
    EV_REJECT   = 3'd4,
    EV_START    = 3'd5
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT = 2'd0,
    REG_ACK     = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DRAIN,
    BK_HOLD
  } back_state_e;

  typedef enum logic [1:0] {
    SLOT_MEM,
    SLOT_PCI,
    SLOT_PAD
  } slot_kind_e;

  // one result job handed from front to back
  typedef struct packed {
    event_e              ev;
    logic                has_pci;
    logic [3:0]          seq;
    logic [ADDR_W-1:0]   base;
    logic [3:0]          nbytes;
    logic [7:0]          sent;
  } job_t;

  // pipeline occupancy seen by the front
  typedef struct packed {
    logic q_empty;
    logic back_busy;
  } pipe_status_t;

endpackage

>>> design/isotp_fcs_if.sv
// channel interfaces of the segmenting sender: items in, results out, register writes
interface isotp_fcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       tx_ready;
  logic       reply_on_text_channel;
  logic [3:0] reply_length;
  logic [7:0] reply_first_byte;

  modport source (
    output valid, cmd, data_byte, last_byte, tx_ready, reply_on_text_channel,
           reply_length, reply_first_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, data_byte, last_byte, tx_ready, reply_on_text_channel,
           reply_length, reply_first_byte,
    output ready
  );
endinterface

interface isotp_fcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [63:0] frame;
  logic [7:0]  bytes_sent;

  modport source (output valid, event_res, frame, bytes_sent, input ready);
  modport sink (input valid, event_res, frame, bytes_sent, output ready);
endinterface

interface isotp_fcs_cfg_if;
  import isotp_fcs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/isotp_fcs_ram.sv
// generic simple dual port ram with registered read
module isotp_fcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/isotp_fcs_front.sv
// front: accepts items, keeps transfer state and the store, issues result jobs
module isotp_fcs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  isotp_fcs_in_if.sink                 in_i,
  isotp_fcs_cfg_if.sink                cfg_i,
  input  isotp_fcs_pkg::pipe_status_t  stat_i,
  output logic                         job_valid_o,
  output isotp_fcs_pkg::job_t          job_o,
  input  logic                         job_ready_i,
  output logic                         we_o,
  output logic [isotp_fcs_pkg::ADDR_W-1:0] waddr_o,
  output logic [7:0]                   wdata_o
);
  import isotp_fcs_pkg::*;

  logic [CNT_W-1:0] load_cnt_q, load_cnt_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] sent_q, sent_d;
  logic [3:0]       seq_q, seq_d;
  logic             active_q, active_d;
  logic             wait_q, wait_d;
  logic [15:0]      timer_q, timer_d;
  logic [15:0]      timeout_q, timeout_d;
  logic [7:0]       ack_q, ack_d;

  logic             accept;
  logic [CNT_W-1:0] cnt_v;
  logic             ovf_v;
  logic [CNT_W-1:0] remain;
  logic [3:0]       nb;

  // store writes wait until no frame build can still read the store
  assign in_i.ready = job_ready_i &&
                      (active_q || (stat_i.q_empty && !stat_i.back_busy));
  assign accept     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign waddr_o = load_cnt_q[ADDR_W-1:0];
  assign wdata_o = in_i.data_byte;

  // bytes left for the next consecutive frame
  assign remain = len_q - sent_q;
  assign nb     = (remain > CNT_W'(CF_DATA)) ? 4'(CF_DATA) : 4'(remain);

  // register writes
  always_comb begin
    timeout_d = timeout_q;
    ack_d     = ack_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_TIMEOUT: timeout_d = cfg_i.data;
        REG_ACK:     ack_d     = cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // item decode and transfer state update
  always_comb begin
    load_cnt_d  = load_cnt_q;
    ovf_d       = ovf_q;
    len_d       = len_q;
    sent_d      = sent_q;
    seq_d       = seq_q;
    active_d    = active_q;
    wait_d      = wait_q;
    timer_d     = timer_q;
    cnt_v       = load_cnt_q;
    ovf_v       = ovf_q;
    we_o        = 1'b0;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (accept) begin
      unique case (cmd_e'(in_i.cmd))
        CMD_LOAD: begin
          if (!active_q) begin
            if (load_cnt_q < CNT_W'(BUFFER_BYTES)) begin
              we_o  = 1'b1;
              cnt_v = load_cnt_q + CNT_W'(1);
            end else begin
              ovf_v = 1'b1;
            end
          end
          load_cnt_d = cnt_v;
          ovf_d      = ovf_v;
          if (in_i.last_byte) begin
            load_cnt_d  = '0;
            ovf_d       = 1'b0;
            job_valid_o = 1'b1;
            if (active_q || ovf_v || (cnt_v < CNT_W'(FRAME_BYTES))) begin
              job_o.ev = EV_REJECT;
            end else begin
              len_d    = cnt_v;
              sent_d   = '0;
              seq_d    = 4'd1;
              active_d = 1'b1;
              wait_d   = 1'b0;
              job_o.ev = EV_START;
            end
          end
        end
        CMD_TICK: begin
          if (active_q) begin
            if (wait_q) begin
              if (timer_q <= 16'd1) begin
                timer_d     = '0;
                active_d    = 1'b0;
                wait_d      = 1'b0;
                job_valid_o = 1'b1;
                job_o.ev    = EV_TIMEOUT;
                job_o.sent  = 8'(sent_q);
              end else begin
                timer_d = timer_q - 16'd1;
              end
            end else if (sent_q >= len_q) begin
              wait_d  = 1'b1;
              timer_d = timeout_q;
            end else if (in_i.tx_ready) begin
              job_valid_o = 1'b1;
              job_o.ev    = EV_FRAME;
              if (sent_q == '0) begin
                // first frame carries the raw leading bytes
                job_o.has_pci = 1'b0;
                job_o.base    = '0;
                job_o.nbytes  = 4'(FRAME_BYTES);
                sent_d        = CNT_W'(FRAME_BYTES);
              end else begin
                job_o.has_pci = 1'b1;
                job_o.seq     = seq_q;
                job_o.base    = ADDR_W'(sent_q - CNT_W'(1));
                job_o.nbytes  = nb;
                sent_d        = sent_q + CNT_W'(nb);
                seq_d         = seq_q + 4'd1;
              end
              job_o.sent = 8'(sent_d);
              wait_d     = 1'b1;
              timer_d    = timeout_q;
            end
          end
        end
        CMD_REPLY: begin
          if (active_q && in_i.reply_on_text_channel &&
              (in_i.reply_length >= FC_MIN_LEN) &&
              (in_i.reply_first_byte[7:4] == FC_PCI_HI)) begin
            if (in_i.reply_first_byte[3:0] == FC_CONTINUE) begin
              wait_d = 1'b0;
            end else if (in_i.reply_first_byte[3:0] == FC_WAIT) begin
              timer_d = timeout_q;
            end else begin
              active_d    = 1'b0;
              wait_d      = 1'b0;
              job_valid_o = 1'b1;
              job_o.ev    = EV_ABORT;
              job_o.sent  = 8'(sent_q);
            end
          end else if ((in_i.reply_length >= ACK_MIN_LEN) &&
                       (in_i.reply_first_byte == ack_q) &&
                       active_q && in_i.reply_on_text_channel) begin
            active_d    = 1'b0;
            wait_d      = 1'b0;
            job_valid_o = 1'b1;
            job_o.ev    = EV_COMPLETE;
            job_o.sent  = 8'(sent_q);
          end
        end
        CMD_CANCEL: begin
          active_d = 1'b0;
          wait_d   = 1'b0;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      ovf_q      <= 1'b0;
      len_q      <= '0;
      sent_q     <= '0;
      seq_q      <= '0;
      active_q   <= 1'b0;
      wait_q     <= 1'b0;
      timer_q    <= '0;
      timeout_q  <= TIMEOUT_RESET;
      ack_q      <= ACK_RESET;
    end else begin
      load_cnt_q <= load_cnt_d;
      ovf_q      <= ovf_d;
      len_q      <= len_d;
      sent_q     <= sent_d;
      seq_q      <= seq_d;
      active_q   <= active_d;
      wait_q     <= wait_d;
      timer_q    <= timer_d;
      timeout_q  <= timeout_d;
      ack_q      <= ack_d;
    end
  end

endmodule

>>> design/isotp_fcs_fifo.sv
// short job queue between front and back
module isotp_fcs_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  input  isotp_fcs_pkg::job_t  push_job_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output isotp_fcs_pkg::job_t  pop_job_o,
  input  logic                 pop_ready_i,
  output logic                 empty_o
);
  import isotp_fcs_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign empty_o      = (cnt_q == '0);
  assign pop_job_o    = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

endmodule

>>> design/isotp_fcs_back.sv
// back: builds frames from the store and drives the result register
module isotp_fcs_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  input  isotp_fcs_pkg::job_t              job_i,
  output logic                             job_ready_o,
  output logic [isotp_fcs_pkg::ADDR_W-1:0] raddr_o,
  input  logic [7:0]                       rdata_i,
  output logic                             busy_o,
  isotp_fcs_out_if.source                  out_o
);
  import isotp_fcs_pkg::*;

  back_state_e       state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              cap_vld_q, cap_vld_d;
  slot_kind_e        kind_q, kind_d;
  job_t              job_q;
  logic [63:0]       frame_q;
  logic              out_vld_q, out_vld_d;
  event_e            out_ev_q;
  logic [63:0]       out_frame_q;
  logic [7:0]        out_sent_q;

  logic              out_free;
  logic              start_frame;
  logic              load_event;
  logic              load_frame;
  logic              issue;
  logic [7:0]        cap_byte;

  assign out_free = !out_vld_q || out_o.ready;
  assign busy_o   = (state_q != BK_IDLE);
  assign raddr_o  = job_q.base + ADDR_W'(slot_q);

  // sequencer outputs
  always_comb begin
    job_ready_o = 1'b0;
    start_frame = 1'b0;
    load_event  = 1'b0;
    load_frame  = 1'b0;
    issue       = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          if (job_i.ev == EV_FRAME) begin
            job_ready_o = 1'b1;
            start_frame = 1'b1;
          end else if (out_free) begin
            job_ready_o = 1'b1;
            load_event  = 1'b1;
          end
        end
      end
      BK_READ:  issue      = 1'b1;
      BK_DRAIN: ;
      BK_HOLD:  load_frame = out_free;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (start_frame) state_d = BK_READ;
      BK_READ:  if (slot_q == SLOT_W'(FRAME_BYTES - 1)) state_d = BK_DRAIN;
      BK_DRAIN: state_d = BK_HOLD;
      BK_HOLD:  if (out_free) state_d = BK_IDLE;
    endcase
  end

  // slot issue: header, store byte or padding
  always_comb begin
    slot_d    = slot_q;
    cap_vld_d = issue;
    kind_d    = kind_q;
    if (start_frame) begin
      slot_d = '0;
    end else if (issue) begin
      slot_d = slot_q + SLOT_W'(1);
      if (job_q.has_pci && (slot_q == '0)) begin
        kind_d = SLOT_PCI;
      end else if (job_q.has_pci && ({1'b0, slot_q} > job_q.nbytes)) begin
        kind_d = SLOT_PAD;
      end else begin
        kind_d = SLOT_MEM;
      end
    end
  end

  // byte captured in the cycle after its read
  always_comb begin
    case (kind_q)
      SLOT_MEM: cap_byte = rdata_i;
      SLOT_PCI: cap_byte = CF_PCI | {4'h0, job_q.seq};
      default:  cap_byte = 8'h00;
    endcase
  end

  // result register handshake
  always_comb begin
    out_vld_d = out_vld_q;
    if (load_event || load_frame) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      slot_q    <= '0;
      cap_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      cap_vld_q <= cap_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // frame assembly and result payload
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    if (start_frame) begin
      job_q <= job_i;
    end
    if (cap_vld_q) begin
      frame_q <= {frame_q[55:0], cap_byte};
    end
    if (load_event) begin
      out_ev_q    <= job_i.ev;
      out_frame_q <= '0;
      out_sent_q  <= job_i.sent;
    end else if (load_frame) begin
      out_ev_q    <= EV_FRAME;
      out_frame_q <= frame_q;
      out_sent_q  <= job_q.sent;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.event_res  = out_ev_q;
  assign out_o.frame      = out_frame_q;
  assign out_o.bytes_sent = out_sent_q;

endmodule

>>> design/isotp_flow_controlled_sender.sv
// top level of the segmenting transport sender with block size one
// Usage: items arrive on in_i (valid/ready): payload loads, bus ticks, reply
// frames and cancel. Results leave on out_o (valid/ready), at most one per
// item and in item order. Registers are written on cfg_i, which is always
// ready: index 0 timeout in ticks, index 1 acknowledge byte.
// Throughput: one item per cycle while a transfer is active and the job queue
// has room. With no transfer active, any item waits until the job queue is
// empty and no frame is built. A non-frame result goes via the job queue to
// the result register; a frame result follows its tick once the back end has
// read the eight frame bytes one per cycle through the store's one read port.
// A 4-entry job queue lets the front keep accepting while frames build.
// When the receiver stalls, the result register holds and the queue fills;
// the front then drops ready until an entry frees up.
// Reset clears all transfer state, loads the timeout with 2000 ticks and
// the acknowledge byte with 0x74; the payload store is not cleared.
module isotp_flow_controlled_sender (
  input  logic            clk_i,
  input  logic            rst_ni,
  isotp_fcs_cfg_if.sink   cfg_i,
  isotp_fcs_in_if.sink    in_i,
  isotp_fcs_out_if.source out_o
);
  import isotp_fcs_pkg::*;

  logic              fe_job_valid;
  job_t              fe_job;
  logic              fe_job_ready;
  logic              be_job_valid;
  job_t              be_job;
  logic              be_job_ready;
  logic              q_empty;
  logic              back_busy;
  pipe_status_t      stat;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // occupancy seen by the front
  assign stat.q_empty   = q_empty;
  assign stat.back_busy = back_busy;

  isotp_fcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .stat_i      (stat),
    .job_valid_o (fe_job_valid),
    .job_o       (fe_job),
    .job_ready_i (fe_job_ready),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata)
  );

  isotp_fcs_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  isotp_fcs_fifo u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_job_valid),
    .push_job_i   (fe_job),
    .push_ready_o (fe_job_ready),
    .pop_valid_o  (be_job_valid),
    .pop_job_o    (be_job),
    .pop_ready_i  (be_job_ready),
    .empty_o      (q_empty)
  );

  isotp_fcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (be_job_valid),
    .job_i       (be_job),
    .job_ready_o (be_job_ready),
    .raddr_o     (ram_raddr),
    .rdata_i     (ram_rdata),
    .busy_o      (back_busy),
    .out_o       (out_o)
  );

endmodule

>>> design/isotp_fcs_checker.sv
// port-level checks on the result channel of the segmenting sender
`include "isotp_flow_controlled_sender_defines.svh"

module isotp_fcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_event_i,
  input logic [63:0] out_frame_i,
  input logic [7:0]  out_sent_i
);
  import isotp_fcs_pkg::*;

  // a stalled result keeps its contents
  `FCS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_event_i) && $stable(out_frame_i) && $stable(out_sent_i), "result changed while stalled")

  // only frame results carry frame bytes
  `FCS_ASSERT_SAME(a_frame_zero, out_valid_i && (out_event_i != EV_FRAME), out_frame_i == 64'd0, "non-frame result with frame data")

  // start decisions report no bytes sent
  `FCS_ASSERT_SAME(a_start_sent, out_valid_i && (out_event_i == EV_REJECT || out_event_i == EV_START), out_sent_i == 8'd0, "start result with nonzero byte count")

endmodule

bind isotp_flow_controlled_sender isotp_fcs_checker u_isotp_fcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_event_i (out_o.event_res),
  .out_frame_i (out_o.frame),
  .out_sent_i  (out_o.bytes_sent)
);
